>>> src/bmf_pkg.sv
// Shared types, widths, codes and default sizes for the box mean filter.
package bmf_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_RADIUS_DEF = 10;

   localparam int PIX_W      = 8;
   localparam int VALUE_W    = 16;
   localparam int COUNT_W    = 9;
   localparam int RADIUS_W   = 6;
   localparam int DIM_W      = 9;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [DIM_W-1:0]    WIDTH_RST  = 9'd256;
   localparam logic [DIM_W-1:0]    HEIGHT_RST = 9'd256;
   localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd1;

   typedef struct packed {
      logic               opcode;
      logic [PIX_W-1:0]   pixel_col;
      logic [PIX_W-1:0]   pixel_row;
      logic [VALUE_W-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] mean_value;
      logic [COUNT_W-1:0] sample_count;
      logic               out_of_frame;
   } rsp_type;

endpackage

>>> src/bmf_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module bmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bmf_div.sv
// Restoring divider, one quotient bit per cycle.
module bmf_div #(
   parameter int NUM_W = 25,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    shifted;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         rem_in  = ge ? DEN_W'(shifted - {1'b0, den_ff}) : DEN_W'(shifted);
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/box_mean_filter.sv
// Box mean filter top level: frame store, window sweep and divider control.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------------------
//   request | req_valid, req_stall, req_data          | write or query in
//   result  | rsp_valid, rsp_stall, rsp_data          | mean of query out
//   config  | csr_valid, csr_ready, csr_index, csr_data | register writes in
//
// A write is accepted in ST_IDLE and stored at once. A query sweeps the (2r+1) square
// window, r the clamped radius, and the next request is taken once its result is loaded
// into the output register: one frame store read per window position, then the divider
// retires one quotient bit per cycle. Reset is synchronous; the frame store has no
// clearing pass. A result waits in the output register under rsp_stall while further
// writes are taken; the next result waits until it drains.
module box_mean_filter #(
   parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = bmf_pkg::MAX_RADIUS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bmf_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bmf_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bmf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bmf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int SPAN_W  = $clog2(2 * MAX_RADIUS + 1);
   localparam int CNT_W   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
   localparam int SUM_W   = bmf_pkg::VALUE_W + CNT_W;
   localparam int COORD_W = $clog2((1 << bmf_pkg::PIX_W) + 2 * MAX_RADIUS) + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SWEEP  = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_DIVIDE = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [bmf_pkg::RADIUS_W-1:0]    radius_ff, radius_in;
   logic [bmf_pkg::DIM_W-1:0]       width_ff, width_in;
   logic [bmf_pkg::DIM_W-1:0]       height_ff, height_in;
   logic [bmf_pkg::PIX_W-1:0]       col_ff, col_in;
   logic [bmf_pkg::PIX_W-1:0]       row_ff, row_in;
   logic [RAD_W-1:0]                rad_ff, rad_in;
   logic [SPAN_W-1:0]               i_ff, i_in;
   logic [SPAN_W-1:0]               j_ff, j_in;
   logic [SUM_W-1:0]                sum_ff, sum_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [bmf_pkg::VALUE_W-1:0]     mean_ff, mean_in;
   logic                            err_ff, err_in;
   logic                            rd_pend_ff, rd_pend_in;
   logic                            div_start_ff, div_start_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bmf_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                            req_accept;
   logic                            req_inside;
   logic                            wr_en;
   logic [ADDR_W-1:0]               wr_addr;
   logic signed [COORD_W-1:0]       win_x;
   logic signed [COORD_W-1:0]       win_y;
   logic [COORD_W-2:0]              win_xu;
   logic [COORD_W-2:0]              win_yu;
   logic                            win_inside;
   logic [ADDR_W-1:0]               rd_addr;
   logic [bmf_pkg::VALUE_W-1:0]     rd_data;
   logic [SPAN_W-1:0]               span_end;
   logic                            div_done;
   logic [SUM_W-1:0]                div_quotient;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_inside = (32'(req_data.pixel_col) < 32'(width_ff))
                    && (32'(req_data.pixel_col) < 32'(MAX_WIDTH))
                    && (32'(req_data.pixel_row) < 32'(height_ff))
                    && (32'(req_data.pixel_row) < 32'(MAX_HEIGHT));

   assign wr_en   = req_accept && (req_data.opcode == bmf_pkg::OP_WRITE) && req_inside;
   assign wr_addr = ADDR_W'(32'(req_data.pixel_row) * MAX_WIDTH + 32'(req_data.pixel_col));

   assign win_x  = COORD_W'(col_ff) - COORD_W'(rad_ff) + COORD_W'(j_ff);
   assign win_y  = COORD_W'(row_ff) - COORD_W'(rad_ff) + COORD_W'(i_ff);
   assign win_xu = win_x[COORD_W-2:0];
   assign win_yu = win_y[COORD_W-2:0];
   assign win_inside = !win_x[COORD_W-1] && !win_y[COORD_W-1]
                    && (32'(win_xu) < 32'(width_ff)) && (32'(win_xu) < 32'(MAX_WIDTH))
                    && (32'(win_yu) < 32'(height_ff)) && (32'(win_yu) < 32'(MAX_HEIGHT));
   assign rd_addr  = ADDR_W'(32'(win_yu) * MAX_WIDTH + 32'(win_xu));
   assign span_end = SPAN_W'(2 * 32'(rad_ff));

   bmf_ram #(
      .WIDTH (bmf_pkg::VALUE_W),
      .DEPTH (DEPTH),
      .AW    (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.pixel_value),
      .rd_en   ((state_ff == ST_SWEEP) && win_inside),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bmf_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      radius_in = radius_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bmf_pkg::CSR_RADIUS: radius_in = csr_data[bmf_pkg::RADIUS_W-1:0];
            bmf_pkg::CSR_WIDTH:  width_in  = csr_data[bmf_pkg::DIM_W-1:0];
            bmf_pkg::CSR_HEIGHT: height_in = csr_data[bmf_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rad_in       = rad_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      mean_in      = mean_ff;
      err_in       = err_ff;
      rd_pend_in   = (state_ff == ST_SWEEP) && win_inside;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rd_pend_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data);
         cnt_in = cnt_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.opcode == bmf_pkg::OP_QUERY)) begin
               if (req_inside) begin
                  col_in   = req_data.pixel_col;
                  row_in   = req_data.pixel_row;
                  rad_in   = (32'(radius_ff) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                               : RAD_W'(radius_ff);
                  i_in     = '0;
                  j_in     = '0;
                  sum_in   = '0;
                  cnt_in   = '0;
                  err_in   = 1'b0;
                  state_in = ST_SWEEP;
               end else begin
                  mean_in  = '0;
                  cnt_in   = '0;
                  err_in   = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SWEEP: begin
            if (j_ff == span_end) begin
               j_in = '0;
               if (i_ff == span_end) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            div_start_in = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mean_in  = bmf_pkg::VALUE_W'(div_quotient);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.mean_value   = mean_ff;
               rsp_data_in.sample_count = bmf_pkg::COUNT_W'(cnt_ff);
               rsp_data_in.out_of_frame = err_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= bmf_pkg::RADIUS_RST;
         width_ff     <= bmf_pkg::WIDTH_RST;
         height_ff    <= bmf_pkg::HEIGHT_RST;
         rd_pend_ff   <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rd_pend_ff   <= rd_pend_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff      <= col_in;
      row_ff      <= row_in;
      rad_ff      <= rad_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      mean_ff     <= mean_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> verif/box_mean_filter_tb.sv
// Self-checking testbench for box_mean_filter: directed and random pixel writes and mean queries.
module box_mean_filter_tb;

   localparam int DRAIN_CYCLES = 600;
   localparam int RANDOM_ITEMS = 500;
   localparam int STORE_DEPTH  = bmf_pkg::MAX_WIDTH_DEF * bmf_pkg::MAX_HEIGHT_DEF;
   localparam int REQ_W        = $bits(bmf_pkg::req_type);
   localparam logic [bmf_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_mode_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   bmf_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   bmf_pkg::rsp_type               rsp_data;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [bmf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bmf_pkg::CSR_DATA_W-1:0] csr_data;

   logic [bmf_pkg::RADIUS_W-1:0]   cfg_radius;
   logic [bmf_pkg::DIM_W-1:0]      cfg_width;
   logic [bmf_pkg::DIM_W-1:0]      cfg_height;
   logic [bmf_pkg::VALUE_W-1:0]    frame_model [0:STORE_DEPTH-1];
   bit                             pix_written [0:STORE_DEPTH-1];
   bmf_pkg::rsp_type               expected_means [$];
   bmf_pkg::rsp_type               oldest_mean;
   int                             fail_count;
   int                             sent_count;
   int                             burst_left;
   bit                             gaps_on;
   int                             spot_col;
   int                             spot_row;
   stall_mode_type                 stall_mode;
   int                             stall_len;

   box_mean_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_cols();
      return (cfg_width > bmf_pkg::MAX_WIDTH_DEF) ? bmf_pkg::MAX_WIDTH_DEF : int'(cfg_width);
   endfunction

   function automatic int eff_rows();
      return (cfg_height > bmf_pkg::MAX_HEIGHT_DEF) ? bmf_pkg::MAX_HEIGHT_DEF
                                                    : int'(cfg_height);
   endfunction

   function automatic int clamp_radius();
      return (cfg_radius > bmf_pkg::MAX_RADIUS_DEF) ? bmf_pkg::MAX_RADIUS_DEF
                                                    : int'(cfg_radius);
   endfunction

   function automatic bit in_frame(input int c, input int r);
      return c >= 0 && r >= 0 && c < eff_cols() && r < eff_rows();
   endfunction

   function automatic bmf_pkg::rsp_type predict_box_mean(input bmf_pkg::req_type rq);
      bmf_pkg::rsp_type rs;
      int unsigned      sum;
      int unsigned      count;
      int               c;
      int               r;
      int               rad;
      int               x;
      int               y;
      c  = int'(rq.pixel_col);
      r  = int'(rq.pixel_row);
      rs = '0;
      if (!in_frame(c, r)) begin
         rs.out_of_frame = 1'b1;
         return rs;
      end
      rad   = clamp_radius();
      sum   = 0;
      count = 0;
      for (y = r - rad; y <= r + rad; y++) begin
         for (x = c - rad; x <= c + rad; x++) begin
            if (in_frame(x, y)) begin
               sum += frame_model[y * bmf_pkg::MAX_WIDTH_DEF + x];
               count++;
            end
         end
      end
      rs.mean_value   = bmf_pkg::VALUE_W'(sum / count);
      rs.sample_count = count[bmf_pkg::COUNT_W-1:0];
      return rs;
   endfunction

   task automatic model_request(input bmf_pkg::req_type rq);
      int idx;
      idx = int'(rq.pixel_row) * bmf_pkg::MAX_WIDTH_DEF + int'(rq.pixel_col);
      if (rq.opcode == bmf_pkg::OP_WRITE) begin
         if (in_frame(int'(rq.pixel_col), int'(rq.pixel_row))) begin
            frame_model[idx] = rq.pixel_value;
            pix_written[idx] = 1'b1;
         end
      end else begin
         expected_means.push_back(predict_box_mean(rq));
      end
   endtask

   function automatic bmf_pkg::req_type make_req(input logic op, input int c, input int r,
                                                 input logic [bmf_pkg::VALUE_W-1:0] v);
      bmf_pkg::req_type rq;
      rq.opcode      = op;
      rq.pixel_col   = c[bmf_pkg::PIX_W-1:0];
      rq.pixel_row   = r[bmf_pkg::PIX_W-1:0];
      rq.pixel_value = v;
      return rq;
   endfunction

   task automatic send_request(input bmf_pkg::req_type rq);
      logic [REQ_W-1:0] noise;
      int               gap;
      if (gaps_on && burst_left == 0) begin
         gap        = $urandom_range(1, 12);
         burst_left = $urandom_range(1, 16);
         repeat (gap) begin
            noise = REQ_W'({$urandom, $urandom});
            @(negedge clock);
            req_valid <= 1'b0;
            req_data  <= noise;
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      sent_count++;
      model_request(rq);
   endtask

   task automatic write_at(input int c, input int r, input logic [bmf_pkg::VALUE_W-1:0] v);
      send_request(make_req(bmf_pkg::OP_WRITE, c, r, v));
   endtask

   // fill every in-frame window pixel not yet written
   task automatic ensure_window(input int c, input int r);
      int rad;
      int x;
      int y;
      if (in_frame(c, r)) begin
         rad = clamp_radius();
         for (y = r - rad; y <= r + rad; y++) begin
            for (x = c - rad; x <= c + rad; x++) begin
               if (in_frame(x, y) && !pix_written[y * bmf_pkg::MAX_WIDTH_DEF + x])
                  write_at(x, y, bmf_pkg::VALUE_W'($urandom));
            end
         end
      end
   endtask

   task automatic query_at(input int c, input int r);
      ensure_window(c, r);
      send_request(make_req(bmf_pkg::OP_QUERY, c, r, bmf_pkg::VALUE_W'($urandom)));
   endtask

   task automatic wait_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
   endtask

   task automatic settle_idle();
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bmf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bmf_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bmf_pkg::CSR_RADIUS: cfg_radius = data[bmf_pkg::RADIUS_W-1:0];
         bmf_pkg::CSR_WIDTH:  cfg_width  = data;
         bmf_pkg::CSR_HEIGHT: cfg_height = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame(input logic [bmf_pkg::CSR_DATA_W-1:0] rad_data,
                            input logic [bmf_pkg::DIM_W-1:0] w,
                            input logic [bmf_pkg::DIM_W-1:0] h);
      settle_idle();
      write_csr(bmf_pkg::CSR_RADIUS, rad_data);
      write_csr(bmf_pkg::CSR_WIDTH, w);
      write_csr(bmf_pkg::CSR_HEIGHT, h);
   endtask

   function automatic logic [bmf_pkg::DIM_W-1:0] pick_dim();
      int sel;
      sel = $urandom_range(0, 11);
      case (sel)
         0:       return '0;
         1:       return 9'd256;
         2:       return bmf_pkg::DIM_W'($urandom_range(257, 511));
         3, 4:    return bmf_pkg::DIM_W'($urandom_range(17, 64));
         default: return bmf_pkg::DIM_W'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic int pick_axis(input int n, input int base);
      int pos;
      if (n <= 24) return $urandom_range(0, n - 1);
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? n - 1 : 0;
      pos = base + $urandom_range(0, 15);
      return (pos > n - 1) ? n - 1 : pos;
   endfunction

   task automatic test_reset_defaults();
      write_at(0, 0, 16'hFFFF);
      write_at(1, 0, 16'hFFFF);
      write_at(0, 1, 16'hFFFF);
      write_at(1, 1, 16'hFFFF);
      query_at(0, 0);
      write_at(255, 255, 16'h0000);
      query_at(255, 255);
      query_at(128, 77);
   endtask

   task automatic test_frame_limits();
      set_frame(9'h1FF, 9'd1, 9'd1);
      write_at(0, 0, 16'h0000);
      write_at(1, 0, 16'hFFFF);
      write_at(0, 1, 16'hFFFF);
      query_at(0, 0);
      query_at(0, 1);
      query_at(255, 255);
   endtask

   task automatic test_empty_frame();
      set_frame(9'd1, 9'd0, 9'd5);
      write_at(0, 0, 16'h1234);
      query_at(0, 0);
      set_frame(9'd1, 9'd5, 9'd0);
      query_at(3, 3);
   endtask

   task automatic test_oversize_frame();
      set_frame(9'd0, 9'd511, 9'd257);
      query_at(255, 255);
      query_at(0, 255);
      write_at(255, 0, 16'h8001);
      query_at(255, 0);
   endtask

   task automatic test_resize_keeps_pixels();
      set_frame(9'd10, 9'd4, 9'd4);
      query_at(2, 2);
      set_frame(9'd10, 9'd6, 9'd3);
      query_at(5, 2);
   endtask

   task automatic test_unused_register();
      settle_idle();
      write_csr(CSR_UNUSED, 9'h1FF);
      query_at(1, 1);
   endtask

   task automatic test_random_traffic();
      int phase;
      int items;
      int n;
      int kind;
      int sel;
      int rad;
      int c;
      int r;
      logic [bmf_pkg::DIM_W-1:0] w_data;
      logic [bmf_pkg::DIM_W-1:0] h_data;
      phase = 0;
      while (sent_count < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) rad = $urandom_range(0, 3);
         else if (sel < 8) rad = $urandom_range(4, 10);
         else if (sel == 8) rad = $urandom_range(11, 63);
         else rad = bmf_pkg::MAX_RADIUS_DEF;
         w_data = pick_dim();
         h_data = pick_dim();
         set_frame({3'($urandom), 6'(rad)}, w_data, h_data);
         gaps_on  = ($urandom_range(0, 3) != 0);
         spot_col = (eff_cols() > 0) ? $urandom_range(0, eff_cols() - 1) : 0;
         spot_row = (eff_rows() > 0) ? $urandom_range(0, eff_rows() - 1) : 0;
         items    = $urandom_range(30, 80);
         for (n = 0; n < items && sent_count < RANDOM_ITEMS; n++) begin
            // hold off until the block has drained completely
            if (phase == 1 && n == items / 2) wait_results();
            kind = $urandom_range(0, 9);
            if (kind <= 6 && eff_cols() > 0 && eff_rows() > 0) begin
               c = pick_axis(eff_cols(), spot_col);
               r = pick_axis(eff_rows(), spot_row);
               if (kind <= 4) query_at(c, r);
               else write_at(c, r, bmf_pkg::VALUE_W'($urandom));
            end else begin
               c = $urandom_range(0, 255);
               r = $urandom_range(0, 255);
               if ($urandom_range(0, 1)) query_at(c, r);
               else write_at(c, r, bmf_pkg::VALUE_W'($urandom));
            end
         end
         phase++;
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_len  = $urandom_range(20, 200);
         repeat (stall_len) begin
            @(negedge clock);
            case (stall_mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_RANDOM: rsp_stall <= 1'($urandom_range(0, 1));
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 7) != 0);
               default:      rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_means.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            fail_count++;
         end else begin
            oldest_mean = expected_means.pop_front();
            if (rsp_data.mean_value !== oldest_mean.mean_value) begin
               $display("%0t: mean_value expected %h actual %h", $time,
                        oldest_mean.mean_value, rsp_data.mean_value);
               fail_count++;
            end
            if (rsp_data.sample_count !== oldest_mean.sample_count) begin
               $display("%0t: sample_count expected %0d actual %0d", $time,
                        oldest_mean.sample_count, rsp_data.sample_count);
               fail_count++;
            end
            if (rsp_data.out_of_frame !== oldest_mean.out_of_frame) begin
               $display("%0t: out_of_frame expected %b actual %b", $time,
                        oldest_mean.out_of_frame, rsp_data.out_of_frame);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      cfg_radius = bmf_pkg::RADIUS_RST;
      cfg_width  = bmf_pkg::WIDTH_RST;
      cfg_height = bmf_pkg::HEIGHT_RST;
      fail_count = 0;
      sent_count = 0;
      burst_left = 0;
      gaps_on    = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_frame_limits();
      test_empty_frame();
      test_oversize_frame();
      test_resize_keeps_pixels();
      test_unused_register();
      test_random_traffic();
      settle_idle();
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
